[rtl/core/fir_lp_pkg.sv]
// ----------------------------------------------------------------------------
// fir_lp_pkg: shared constants and coefficient function for the low-pass FIR
// Holds the sample format, the symmetric 45-tap design and the helper that
// turns a design tap into a signed fixed-point coefficient at elaboration.
// ----------------------------------------------------------------------------
package fir_lp_pkg;

  // Sample format.
  localparam int SAMPLE_W   = 16;
  localparam int SAMPLE_MAX = 32767;
  localparam int SAMPLE_MIN = -32768;

  // Number of taps in the original design and in its stored half.
  localparam int DESIGN_TAPS = 45;
  localparam int HALF_TAPS   = 23;

  // Design taps are held exactly in units of 1e-10.
  localparam longint COEF_SCALE = 64'sd10000000000;
  localparam longint COEF_HALF  = 64'sd5000000000;

  // First half of the symmetric design, taps 0 to 22.
  localparam longint HALF_DESIGN [HALF_TAPS] = '{
    -64'sd18390000,   -64'sd26570000,   -64'sd1437,       64'sd31540000,
    64'sd25950000,    -64'sd41590000,   -64'sd154000000,  -64'sd250700000,
    -64'sd254700000,  -64'sd117900000,  64'sd139200000,   64'sd420600000,
    64'sd588800000,   64'sd530700000,   64'sd222500000,   -64'sd241000000,
    -64'sd675400000,  -64'sd883100000,  -64'sd747500000,  -64'sd295600000,
    64'sd303000000,   64'sd805000000,   64'sd1000000000
  };

  // Coefficient of tap z with frac fraction bits, rounded to nearest with
  // ties away from zero. Taps outside the design are zero.
  function automatic longint tap_coef(input int z, input int frac);
    longint v;
    longint mag;
    longint q;
    int     idx;
    if ((z < 0) || (z >= DESIGN_TAPS)) begin
      return 64'sd0;
    end
    idx = (z < HALF_TAPS) ? z : (DESIGN_TAPS - 1 - z);
    v   = HALF_DESIGN[idx];
    mag = (v < 0) ? -v : v;
    q   = (mag * (64'sd1 <<< frac) + COEF_HALF) / COEF_SCALE;
    return (v < 0) ? -q : q;
  endfunction

endpackage

[rtl/core/fir_lowpass_45tap.sv]
// ----------------------------------------------------------------------------
// fir_lowpass_45tap: symmetric 45-tap low-pass FIR, cutoff at fs/10
// Filters a stream of signed 16-bit mono samples, one result per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_sample and in_start_block.
//   Setting in_start_block clears the filter history before that sample, so
//   the first results of a block only see samples of that block.
//   Result channel out_valid/out_ready carries out_filtered, the sum of
//   products divided by 2^COEF_FRAC_BITS, truncated toward zero and
//   saturated to 16 bits.
//   Results pass the input, partial-sum and result registers. Throughput:
//   one sample per cycle unless stalled. In transposed form, for each
//   sample every tap cell does one constant multiply and one add into
//   its partial-sum register; three register stages hold items in flight.
//   Reset clears the partial sums (empty history) and all valid flags.
//   When the receiver stalls, the result register holds its transaction
//   and the stages behind it fill; in_ready drops once all are full.
// ----------------------------------------------------------------------------
module fir_lowpass_45tap #(
  parameter int TAPS           = 45,
  parameter int COEF_FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [fir_lp_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                   in_start_block,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fir_lp_pkg::SAMPLE_W-1:0] out_filtered
);

  localparam int COEF_W = COEF_FRAC_BITS;
  localparam int ACC_W  = fir_lp_pkg::SAMPLE_W + COEF_W + $clog2(TAPS);

  logic signed [fir_lp_pkg::SAMPLE_W-1:0] sample_r;
  logic signed [fir_lp_pkg::SAMPLE_W-1:0] sample_nxt;
  logic                                   start_r;
  logic                                   start_nxt;
  logic                                   s1_valid_r;
  logic                                   s1_valid_nxt;
  logic                                   acc_valid_r;
  logic                                   acc_valid_nxt;
  logic                                   acc_ready;
  logic                                   adv1;
  logic signed [ACC_W-1:0]                psum [TAPS];

  // Stage one moves into the tap chain when the sum register is free or being drained.
  assign adv1     = s1_valid_r && (!acc_valid_r || acc_ready);
  assign in_ready = !s1_valid_r || adv1;

  // Input register.
  always_comb begin
    sample_nxt   = sample_r;
    start_nxt    = start_r;
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      sample_nxt   = in_sample;
      start_nxt    = in_start_block;
      s1_valid_nxt = 1'b1;
    end else if (adv1) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    start_r  <= start_nxt;
  end

  // Sum register valid flag; cell zero's register holds the sum itself.
  always_comb begin
    acc_valid_nxt = acc_valid_r;
    if (adv1) begin
      acc_valid_nxt = 1'b1;
    end else if (acc_ready) begin
      acc_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= acc_valid_nxt;
    end
  end

  // Transposed tap chain; the last cell starts from zero.
  for (genvar z = 0; z < TAPS; z++) begin : g_tap
    localparam logic signed [COEF_W-1:0] C =
      COEF_W'(fir_lp_pkg::tap_coef(z, COEF_FRAC_BITS));
    logic signed [ACC_W-1:0] p_in;

    if (z == TAPS - 1) begin : g_last
      assign p_in = '0;
    end else begin : g_mid
      assign p_in = psum[z+1];
    end

    fir_lp_tap #(
      .COEF_W (COEF_W),
      .ACC_W  (ACC_W),
      .COEF   (C)
    ) u_tap (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv1),
      .clr   (start_r),
      .x     (sample_r),
      .p_in  (p_in),
      .p_out (psum[z])
    );
  end

  // Scaling, saturation and result register.
  fir_lp_out #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (COEF_FRAC_BITS)
  ) u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc_valid    (acc_valid_r),
    .acc_ready    (acc_ready),
    .acc          (psum[0]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_filtered (out_filtered)
  );

endmodule

[rtl/core/fir_lp_tap.sv]
// ----------------------------------------------------------------------------
// fir_lp_tap: one cell of the transposed-form filter
// Multiplies the current sample by a fixed coefficient and adds the partial
// sum coming from the next cell; the result is held in this cell's register.
// ----------------------------------------------------------------------------
module fir_lp_tap #(
  parameter int                      COEF_W = 15,
  parameter int                      ACC_W  = 37,
  parameter logic signed [COEF_W-1:0] COEF  = '0
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      en,
  input  logic                                      clr,
  input  logic signed [fir_lp_pkg::SAMPLE_W-1:0]    x,
  input  logic signed [ACC_W-1:0]                   p_in,
  output logic signed [ACC_W-1:0]                   p_out
);

  localparam int PROD_W = fir_lp_pkg::SAMPLE_W + COEF_W;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  p_r;
  logic signed [ACC_W-1:0]  p_nxt;

  // Constant multiply of the sample.
  assign prod = PROD_W'(x) * PROD_W'(COEF);

  // A block start drops everything older than the current sample.
  always_comb begin
    p_nxt = p_r;
    if (en) begin
      p_nxt = ACC_W'(prod) + (clr ? ACC_W'(0) : p_in);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '0;
    end else begin
      p_r <= p_nxt;
    end
  end

  assign p_out = p_r;

endmodule

[rtl/core/fir_lp_out.sv]
// ----------------------------------------------------------------------------
// fir_lp_out: output stage of the low-pass FIR
// Scales the full-precision sum down, truncating toward zero, saturates it
// to 16 bits and holds it in the result register for the receiver.
// ----------------------------------------------------------------------------
module fir_lp_out #(
  parameter int ACC_W     = 37,
  parameter int FRAC_BITS = 15
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   acc_valid,
  output logic                                   acc_ready,
  input  logic signed [ACC_W-1:0]                acc,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [fir_lp_pkg::SAMPLE_W-1:0] out_filtered
);

  localparam int QW = ACC_W - FRAC_BITS;

  logic signed [QW-1:0]                   quot;
  logic                                   rnd_up;
  logic signed [QW-1:0]                   quot_tz;
  logic signed [fir_lp_pkg::SAMPLE_W-1:0] sat;
  logic                                   valid_r;
  logic                                   valid_nxt;
  logic signed [fir_lp_pkg::SAMPLE_W-1:0] filtered_r;
  logic signed [fir_lp_pkg::SAMPLE_W-1:0] filtered_nxt;

  // Arithmetic shift floors; step up by one for a negative inexact sum.
  assign quot    = QW'(acc >>> FRAC_BITS);
  assign rnd_up  = acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]);
  assign quot_tz = quot + QW'(rnd_up);

  // Clamp to the sample range.
  always_comb begin
    if (quot_tz > QW'(fir_lp_pkg::SAMPLE_MAX)) begin
      sat = fir_lp_pkg::SAMPLE_W'(fir_lp_pkg::SAMPLE_MAX);
    end else if (quot_tz < QW'(fir_lp_pkg::SAMPLE_MIN)) begin
      sat = fir_lp_pkg::SAMPLE_W'(fir_lp_pkg::SAMPLE_MIN);
    end else begin
      sat = quot_tz[fir_lp_pkg::SAMPLE_W-1:0];
    end
  end

  // The register takes a new sum whenever it is empty or being drained.
  assign acc_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt    = valid_r;
    filtered_nxt = filtered_r;
    if (acc_ready) begin
      valid_nxt = acc_valid;
      if (acc_valid) begin
        filtered_nxt = sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    filtered_r <= filtered_nxt;
  end

  assign out_valid    = valid_r;
  assign out_filtered = filtered_r;

endmodule

[rtl/core/fir_lp_chk.sv]
// ----------------------------------------------------------------------------
// fir_lp_chk: port-level checks for the low-pass FIR
// Tracks transactions in flight and checks the result channel against them.
// ----------------------------------------------------------------------------
module fir_lp_chk (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [fir_lp_pkg::SAMPLE_W-1:0] out_filtered
);

  logic [2:0] inflight_r;
  logic [2:0] inflight_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count of input transactions whose result has not yet been taken.
  always_comb begin
    inflight_nxt = inflight_r + 3'(in_acc) - 3'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("result changed or dropped while stalled");

  // No result without a pending input.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 3'd0)
    else $error("result shown with no input pending");

  // At most three items are held inside the filter.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'd3)
    else $error("more items in flight than register stages");

  // Reset empties the result channel.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind fir_lowpass_45tap fir_lp_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_filtered (out_filtered)
);
